### hdl/assert_macros.svh
// Assertion macros shared by the splitter RTL.
// No dependencies; pulled in by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cond must never hold.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### hdl/cwsms_pkg.sv
// Package for the CW speed-modifier splitter: constants, job type, helpers.
// No dependencies; imported by every module of the block.
`default_nettype none

package cwsms_pkg;

   localparam int MAX_PREFIX  = 16;
   localparam int LEN_W       = $clog2(MAX_PREFIX + 1);
   localparam int IDX_W       = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WPM   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_STEP = 1'b1;

   localparam logic [6:0] WPM_MIN  = 7'd5;
   localparam logic [6:0] WPM_MAX  = 7'd100;
   localparam logic [4:0] STEP_MIN = 5'd1;
   localparam logic [4:0] STEP_MAX = 5'd20;
   localparam logic [6:0] BASE_RST = 7'd20;
   localparam logic [4:0] STEP_RST = 5'd5;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] WS_LO      = 8'h09;
   localparam logic [7:0] WS_HI      = 8'h0D;

   // One item's worth of work for the back end: an optional literal flush
   // of the held run, then an optional ordinary character.
   typedef struct packed {
      logic [LEN_W-1:0]      flush_len;
      logic [MAX_PREFIX-1:0] flush_run;   // bit i set: i-th held char was '+'
      logic [6:0]            flush_wpm;
      logic                  flush_seg;
      logic                  has_char;
      logic [7:0]            chr;
      logic [6:0]            char_wpm;
      logic                  char_seg;
      logic                  ovf;
   } job_type;

   function automatic logic [6:0] clamp_base(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (v < WPM_MIN) r = WPM_MIN;
      else if (v > WPM_MAX) r = WPM_MAX;
      return r;
   endfunction

   function automatic logic [4:0] clamp_step(input logic [4:0] v);
      logic [4:0] r;
      r = v;
      if (v < STEP_MIN) r = STEP_MIN;
      else if (v > STEP_MAX) r = STEP_MAX;
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return ((c >= WS_LO) && (c <= WS_HI)) || (c == CHAR_SPACE);
   endfunction

endpackage

`default_nettype wire

### hdl/cwsms_front.sv
// Front end: takes input beats, tracks word and segment state, builds jobs.
// Depends on cwsms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cwsms_front
   import cwsms_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_last_char,
   input  wire logic [6:0] base_wpm,
   input  wire logic [4:0] speed_step,
   input  wire logic       q_full,
   output logic            q_push,
   output job_type         q_job
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;
   localparam int   SUM_W  = LEN_W + 8;
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(WPM_MIN);
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(WPM_MAX);

   logic [0:0]            state_ff, state_in;
   logic [7:0]            char_ff;
   logic                  lastc_ff;
   logic                  after_space_ff, after_space_in;
   logic [MAX_PREFIX-1:0] run_ff, run_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      plus_ff, plus_in;
   logic [LEN_W-1:0]      minus_ff, minus_in;
   logic [6:0]            word_speed_ff, word_speed_in;
   logic                  word_mod_ff, word_mod_in;
   logic [6:0]            seg_speed_ff, seg_speed_in;
   logic                  seg_empty_ff, seg_empty_in;
   logic                  over_ff, over_in;

   logic                  accept, do_work;
   logic [6:0]            eb;
   logic [4:0]            es;
   logic                  ws, pm, is_plus, hold;
   logic signed [LEN_W:0]   diff;
   logic signed [5:0]       step_s;
   logic signed [SUM_W-1:0] prod, sum;
   logic [6:0]            mod_speed;
   job_type               job;

   assign accept    = req_valid && !req_stall;
   assign do_work   = (state_ff == S_WORK) && !q_full;
   assign req_stall = (state_ff != S_IDLE);

   assign eb      = clamp_base(base_wpm);
   assign es      = clamp_step(speed_step);
   assign ws      = is_space(char_ff);
   assign is_plus = (char_ff == CHAR_PLUS);
   assign pm      = is_plus || (char_ff == CHAR_MINUS);
   assign hold    = pm && after_space_ff;

   // modifier speed: base + (pluses - minuses) * step, clamped
   assign diff   = $signed({1'b0, plus_ff}) - $signed({1'b0, minus_ff});
   assign step_s = $signed({1'b0, es});
   assign prod   = diff * step_s;
   assign sum    = $signed({{(LEN_W + 1){1'b0}}, eb}) + prod;

   always_comb begin
      if (sum < SUM_MIN) begin
         mod_speed = WPM_MIN;
      end else if (sum > SUM_MAX) begin
         mod_speed = WPM_MAX;
      end else begin
         mod_speed = sum[6:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_WORK;
         S_WORK: if (!q_full) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Walk one item through the word/segment rules, in model order.
   always_comb begin
      after_space_in = after_space_ff;
      run_in         = run_ff;
      len_in         = len_ff;
      plus_in        = plus_ff;
      minus_in       = minus_ff;
      word_speed_in  = word_speed_ff;
      word_mod_in    = word_mod_ff;
      seg_speed_in   = seg_speed_ff;
      seg_empty_in   = seg_empty_ff;
      over_in        = over_ff;
      job            = '0;
      q_push         = 1'b0;

      if (hold) begin
         if (len_ff < LEN_W'(MAX_PREFIX)) begin
            run_in[len_ff[IDX_W-1:0]] = is_plus;
            len_in = len_ff + LEN_W'(1);
            if (is_plus) plus_in = plus_ff + LEN_W'(1);
            else minus_in = minus_ff + LEN_W'(1);
         end else begin
            over_in = 1'b1;
         end
         if (lastc_ff) begin
            // end of message: the run goes out as literal text
            if (eb != seg_speed_in) begin
               seg_empty_in = 1'b1;
               seg_speed_in = eb;
            end
            word_speed_in  = eb;
            after_space_in = 1'b0;
            word_mod_in    = 1'b0;
            job.flush_len  = len_in;
            job.flush_run  = run_in;
            job.flush_wpm  = eb;
            job.flush_seg  = seg_empty_in;
            seg_empty_in   = 1'b0;
            job.has_char   = 1'b0;
            job.ovf        = over_in;
            q_push         = do_work;
         end
      end else begin
         if (len_ff != '0) begin
            job.ovf = over_ff;
            if (ws) begin
               if (eb != seg_speed_in) begin
                  seg_empty_in = 1'b1;
                  seg_speed_in = eb;
               end
               word_speed_in  = eb;
               after_space_in = 1'b0;
               word_mod_in    = 1'b0;
               job.flush_len  = len_ff;
               job.flush_run  = run_ff;
               job.flush_wpm  = eb;
               job.flush_seg  = seg_empty_in;
               seg_empty_in   = 1'b0;
            end else begin
               if (mod_speed != seg_speed_in) begin
                  seg_empty_in = 1'b1;
                  seg_speed_in = mod_speed;
               end
               word_speed_in  = mod_speed;
               after_space_in = 1'b0;
               word_mod_in    = 1'b1;
            end
            len_in   = '0;
            plus_in  = '0;
            minus_in = '0;
         end
         if (ws) begin
            if (word_mod_in) begin
               seg_empty_in = 1'b1;
               seg_speed_in = eb;
               word_mod_in  = 1'b0;
            end
            job.chr        = CHAR_SPACE;
            job.char_wpm   = seg_speed_in;
            job.char_seg   = seg_empty_in;
            seg_empty_in   = 1'b0;
            after_space_in = 1'b1;
         end else begin
            if (after_space_in) begin
               if (eb != seg_speed_in) begin
                  seg_empty_in = 1'b1;
                  seg_speed_in = eb;
               end
               word_speed_in  = eb;
               after_space_in = 1'b0;
               word_mod_in    = 1'b0;
            end
            job.chr      = char_ff;
            job.char_wpm = word_speed_in;
            job.char_seg = seg_empty_in;
            seg_empty_in = 1'b0;
         end
         job.has_char = 1'b1;
         over_in      = 1'b0;
         q_push       = do_work;
      end

      if (lastc_ff) begin
         after_space_in = 1'b1;
         len_in         = '0;
         plus_in        = '0;
         minus_in       = '0;
         word_speed_in  = '0;
         word_mod_in    = 1'b0;
         seg_speed_in   = eb;
         seg_empty_in   = 1'b1;
         over_in        = 1'b0;
      end
   end

   assign q_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         after_space_ff <= 1'b1;
         len_ff         <= '0;
         plus_ff        <= '0;
         minus_ff       <= '0;
         word_speed_ff  <= '0;
         word_mod_ff    <= 1'b0;
         seg_speed_ff   <= BASE_RST;
         seg_empty_ff   <= 1'b1;
         over_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_work) begin
            after_space_ff <= after_space_in;
            len_ff         <= len_in;
            plus_ff        <= plus_in;
            minus_ff       <= minus_in;
            word_speed_ff  <= word_speed_in;
            word_mod_ff    <= word_mod_in;
            seg_speed_ff   <= seg_speed_in;
            seg_empty_ff   <= seg_empty_in;
            over_ff        <= over_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff  <= req_char_code;
         lastc_ff <= req_last_char;
      end
      if (do_work) begin
         run_ff <= run_in;
      end
   end

   // a run is only ever held at the start of a word
   `ASSERT_IMPL(a_run_at_word_start, clock, reset, len_ff != '0, after_space_ff, "run held mid-word")

endmodule

`default_nettype wire

### hdl/cwsms_queue.sv
// Short job queue between front and back ends.
// Depends on cwsms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cwsms_queue
   import cwsms_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_job = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= push_job;
   end

   `ASSERT_NEVER(a_no_push_full, clock, reset, push && full, "job pushed into full queue")
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && empty, "job popped from empty queue")

endmodule

`default_nettype wire

### hdl/cwsms_back.sv
// Back end: expands one job into result beats, one beat per cycle unless stalled.
// Depends on cwsms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cwsms_back
   import cwsms_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire job_type q_job,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [7:0]   rsp_out_char,
   output logic [6:0]   rsp_out_wpm,
   output logic         rsp_seg_start,
   output logic         rsp_prefix_overflow,
   output logic         rsp_last
);

   logic       job_valid_ff, job_valid_in;
   job_type    job_ff, job_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic [6:0] wpm_ff, wpm_in;
   logic       seg_ff, seg_in;
   logic       ovf_ff;
   logic       last_ff, last_in;
   logic       load;

   assign q_pop = !job_valid_ff && !q_empty;
   assign load  = job_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      char_in      = char_ff;
      wpm_in       = wpm_ff;
      seg_in       = seg_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (q_pop) begin
         job_valid_in = 1'b1;
         job_in       = q_job;
      end else if (load) begin
         rsp_valid_in = 1'b1;
         if (job_ff.flush_len != '0) begin
            // next held character, oldest first
            char_in = job_ff.flush_run[0] ? CHAR_PLUS : CHAR_MINUS;
            wpm_in  = job_ff.flush_wpm;
            seg_in  = job_ff.flush_seg;
            last_in = !job_ff.has_char && (job_ff.flush_len == LEN_W'(1));
            job_in.flush_run = job_ff.flush_run >> 1;
            job_in.flush_len = job_ff.flush_len - LEN_W'(1);
            job_in.flush_seg = 1'b0;
            job_valid_in     = !last_in;
         end else begin
            char_in      = job_ff.chr;
            wpm_in       = job_ff.char_wpm;
            seg_in       = job_ff.char_seg;
            last_in      = 1'b1;
            job_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      char_ff <= char_in;
      wpm_ff  <= wpm_in;
      seg_ff  <= seg_in;
      last_ff <= last_in;
      if (load) ovf_ff <= job_ff.ovf;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_char        = char_ff;
   assign rsp_out_wpm         = wpm_ff;
   assign rsp_seg_start       = seg_ff;
   assign rsp_prefix_overflow = ovf_ff;
   assign rsp_last            = last_ff;

   // a flush-only job must still have a held character to send
   `ASSERT_IMPL(a_flush_nonempty, clock, reset, job_valid_ff && !job_ff.has_char, job_ff.flush_len != '0, "empty job in flight")

endmodule

`default_nettype wire

### hdl/cw_speed_modifier_splitter_top.sv
// Top level of the CW speed-modifier splitter: settings registers and wiring.
// Depends on cwsms_pkg, cwsms_front, cwsms_queue and cwsms_back.
`default_nettype none

// Streams message characters for a Morse keyer and tags each one with its
// keying speed. A run of '+'/'-' at the start of a word is held back: if a
// word character follows, that word keys at base_wpm + (pluses - minuses) *
// speed_step, clamped to 5..100 wpm, and the next word returns to base; if
// whitespace or the end of the message follows, the run goes out as literal
// text. Whitespace is sent as a space. seg_start marks the first beat of each
// speed segment; prefix_overflow flags beats of an item that resolved a run
// longer than the 16 stored characters (the extra ones are dropped); last
// marks the final beat caused by an input beat.
// Timing: the front end first captures an input beat, then classifies it and
// updates the word state; req_stall is high from the capture until the job
// is in the queue, so it takes no new beat while it works on one. The back
// end fetches a job from the two-entry queue and then sends one result beat
// per cycle while rsp_stall is low; it fetches no new job until it has loaded
// the last beat of the current one. A held '+'/'-' that is not the last of
// the message gives no result beat.
// Settings written on csr_* take effect from the next word; write them only
// while the block is idle.

module cw_speed_modifier_splitter_top
   import cwsms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_char_code,
   input  wire logic                  req_last_char,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_char,
   output logic [6:0]                 rsp_out_wpm,
   output logic                       rsp_seg_start,
   output logic                       rsp_prefix_overflow,
   output logic                       rsp_last,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // raw settings; clamping happens where they are used
   logic [6:0] base_wpm_ff, base_wpm_in;
   logic [4:0] speed_step_ff, speed_step_in;

   logic    q_full, q_empty, q_push, q_pop;
   job_type push_job, pop_job;

   always_comb begin
      base_wpm_in   = base_wpm_ff;
      speed_step_in = speed_step_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BASE_WPM:   base_wpm_in   = csr_wdata[6:0];
            CSR_SPEED_STEP: speed_step_in = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_wpm_ff   <= BASE_RST;
         speed_step_ff <= STEP_RST;
      end else begin
         base_wpm_ff   <= base_wpm_in;
         speed_step_ff <= speed_step_in;
      end
   end

   // front end: input beats in, jobs out
   cwsms_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .base_wpm      (base_wpm_ff),
      .speed_step    (speed_step_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   // decouples the two ends so each can stall on its own
   cwsms_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // back end: jobs in, result beats out through an output register
   cwsms_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_job               (pop_job),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_char        (rsp_out_char),
      .rsp_out_wpm         (rsp_out_wpm),
      .rsp_seg_start       (rsp_seg_start),
      .rsp_prefix_overflow (rsp_prefix_overflow),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire
